// ===== hw/rtl/ogru_pkg.sv =====
// Shared types, constants and codes for the occupancy grid ray update unit.
`timescale 1ns / 1ps

package ogru_pkg;

    // Field widths fixed by the request and result formats.
    localparam int COORD_W    = 7;
    localparam int REQ_TYPE_W = 2;
    localparam int LO_W       = 16;
    localparam int INC_W      = 16;
    localparam int HIT_W      = 15;
    localparam int MAX_W      = 15;
    localparam int CNT_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top level parameters.
    localparam int GRID_SIDE_DEF      = 128;
    localparam int LOG_ODDS_WIDTH_DEF = 16;
    localparam int CMD_QUEUE_DEPTH    = 2;

    // Request type codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_TRACE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_INC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LO   = 2'd3;

    // Configuration reset values, Q8.8.
    localparam logic [HIT_W-1:0]        HIT_INC_RST  = 15'd217;
    localparam logic signed [INC_W-1:0] MISS_INC_RST = -16'sd104;
    localparam logic signed [LO_W-1:0]  MIN_LO_RST   = -16'sd510;
    localparam logic [MAX_W-1:0]        MAX_LO_RST   = 15'd890;

    // Classified command passed from the front end to the execution side.
    typedef enum logic [1:0] {
        CMD_TRACE,
        CMD_READ,
        CMD_CLEAR,
        CMD_NOP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic               hit;
    } cmd_t;

    typedef struct packed {
        logic [HIT_W-1:0]        hit_increment;
        logic signed [INC_W-1:0] miss_increment;
        logic signed [LO_W-1:0]  min_log_odds;
        logic [MAX_W-1:0]        max_log_odds;
    } cfg_t;

    // Execution side sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_CLEAR,
        ST_RESP
    } back_state_t;

endpackage

// ===== hw/rtl/ogru_intf.sv =====
// Request and result channel interfaces of the occupancy grid ray update unit.
`timescale 1ns / 1ps

interface ogru_req_if import ogru_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [COORD_W-1:0]    origin_x;
    logic [COORD_W-1:0]    origin_y;
    logic [COORD_W-1:0]    end_x;
    logic [COORD_W-1:0]    end_y;
    logic                  endpoint_hit;
    logic [COORD_W-1:0]    read_x;
    logic [COORD_W-1:0]    read_y;

    modport source (
        output valid, req_type, origin_x, origin_y, end_x, end_y, endpoint_hit,
               read_x, read_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, origin_x, origin_y, end_x, end_y, endpoint_hit,
               read_x, read_y,
        output ready
    );
endinterface

interface ogru_rsp_if import ogru_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [LO_W-1:0] cell_log_odds;
    logic                   cell_observed;
    logic                   has_bounds;
    logic [COORD_W-1:0]     bound_min_x;
    logic [COORD_W-1:0]     bound_max_x;
    logic [COORD_W-1:0]     bound_min_y;
    logic [COORD_W-1:0]     bound_max_y;
    logic [CNT_W-1:0]       observed_count;

    modport source (
        output valid, cell_log_odds, cell_observed, has_bounds, bound_min_x,
               bound_max_x, bound_min_y, bound_max_y, observed_count,
        input  ready
    );
    modport sink (
        input  valid, cell_log_odds, cell_observed, has_bounds, bound_min_x,
               bound_max_x, bound_min_y, bound_max_y, observed_count,
        output ready
    );
endinterface

// ===== hw/rtl/ogru_front.sv =====
// Front end: accepts requests and classifies them into commands for the queue.
`timescale 1ns / 1ps

module ogru_front import ogru_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    ogru_req_if.sink   req,
    input  logic       queue_full,
    input  logic       back_ready,
    output logic       push,
    output cmd_t       cmd
);

    function automatic logic on_grid(input logic [COORD_W-1:0] c);
        on_grid = (int'(c) < GRID_SIDE);
    endfunction

    logic trace_ok;
    logic read_ok;

    // Requests are held off while the queue is full or the map is being initialized.
    assign req.ready = !queue_full && back_ready;
    assign push      = req.valid && req.ready;

    assign trace_ok = on_grid(req.origin_x) && on_grid(req.origin_y)
                   && on_grid(req.end_x) && on_grid(req.end_y);
    assign read_ok  = on_grid(req.read_x) && on_grid(req.read_y);

    // Off-grid traces and reads, and the unused code, leave the map alone
    // and report zero cell fields, so they all become a no-op.
    always_comb
    begin
        cmd.ax  = req.origin_x;
        cmd.ay  = req.origin_y;
        cmd.bx  = req.end_x;
        cmd.by  = req.end_y;
        cmd.hit = req.endpoint_hit;
        unique case (req.req_type)
            REQ_TRACE: cmd.op = trace_ok ? CMD_TRACE : CMD_NOP;
            REQ_READ:
            begin
                cmd.op = read_ok ? CMD_READ : CMD_NOP;
                cmd.ax = req.read_x;
                cmd.ay = req.read_y;
            end
            REQ_CLEAR: cmd.op = CMD_CLEAR;
            default:   cmd.op = CMD_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/ogru_cmd_queue.sv =====
// Small command queue that decouples the front end from the execution side.
`timescale 1ns / 1ps

module ogru_cmd_queue import ogru_pkg::*; #(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ogru_back.sv =====
// Execution side: ray walker, cell memories, map bounds and the result register.
`timescale 1ns / 1ps

module ogru_back import ogru_pkg::*; #(
    parameter int GRID_SIDE      = GRID_SIDE_DEF,
    parameter int LOG_ODDS_WIDTH = LOG_ODDS_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        ready,
    ogru_rsp_if.source  rsp
);

    localparam int AW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CAW   = $clog2(CELLS);
    localparam int LW    = LOG_ODDS_WIDTH;
    localparam int SUM_W = ((LW > INC_W) ? LW : INC_W) + 1;
    localparam int ERR_W = COORD_W + 3;
    localparam int E2_W  = ERR_W + 1;

    localparam logic [AW-1:0]           LAST_ROW = AW'(GRID_SIDE - 1);
    localparam logic [CAW-1:0]          SIDE_C   = CAW'(GRID_SIDE);
    localparam logic signed [SUM_W-1:0] LIM_HI   = SUM_W'((longint'(1) << (LW - 1)) - 1);
    localparam logic signed [SUM_W-1:0] LIM_LO   = -LIM_HI - SUM_W'(1);
    localparam logic signed [ERR_W-1:0] ERR_ZERO = '0;

    // Cell memories: values per cell, observed bits packed one row per word.
    logic signed [LW-1:0]  value_mem [CELLS];
    logic [GRID_SIDE-1:0]  seen_mem  [GRID_SIDE];

    back_state_t state_reg, state_next;

    // Sequencer controls.
    logic pop_now;
    logic issue;
    logic clearing;
    logic load_out;
    logic out_free;
    logic clr_last;

    // Walker registers.
    logic [COORD_W-1:0]      cx_reg, cy_reg, tx_reg, ty_reg;
    logic signed [ERR_W-1:0] dx_reg, dy_reg, err_reg;
    logic                    sx_reg, sy_reg, hit_reg;
    logic                    last_cell;

    // Walker load and step logic.
    logic signed [ERR_W-1:0] ld_ddx, ld_ddy, ld_dx, ld_dy;
    logic signed [E2_W-1:0]  e2, dx_e, dy_n;
    logic                    step_x, step_y;
    logic signed [ERR_W-1:0] err_step;
    logic [COORD_W-1:0]      cx_step, cy_step;

    // Memory read side.
    logic [COORD_W-1:0]   rd_x, rd_y;
    logic [AW-1:0]        rd_row;
    logic [CAW-1:0]       rd_addr;
    logic signed [LW-1:0] val_rd_reg;
    logic [GRID_SIDE-1:0] row_rd_reg;

    // Update stage registers.
    logic                    b_valid_reg;
    logic [COORD_W-1:0]      b_x_reg, b_y_reg;
    logic [CAW-1:0]          b_addr_reg;
    logic signed [INC_W-1:0] b_inc_reg;
    logic signed [INC_W-1:0] issue_inc;
    logic                    fwd_reg;
    logic [GRID_SIDE-1:0]    fwd_row_reg;

    // Update stage arithmetic.
    logic [GRID_SIDE-1:0]    row_eff, row_new;
    logic                    fresh;
    logic signed [LW-1:0]    old_v, new_val;
    logic signed [SUM_W-1:0] old_ext, inc_ext, sum, max_ext, min_ext, v1, v2, v3;

    // Row write port.
    logic                 row_we;
    logic [AW-1:0]        row_wr_idx;
    logic [GRID_SIDE-1:0] row_wr_data;
    logic [AW-1:0]        clr_row_reg;

    // Map bounds and count.
    logic               bnd_valid_reg;
    logic [COORD_W-1:0] bmin_x_reg, bmax_x_reg, bmin_y_reg, bmax_y_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Read result and output register.
    logic [AW-1:0]          rd_col_reg;
    logic signed [LO_W-1:0] res_val_reg;
    logic                   res_obs_reg;
    logic                   out_valid_reg;
    logic signed [LO_W-1:0] out_val_reg;
    logic                   out_obs_reg;
    logic                   out_bv_reg;
    logic [COORD_W-1:0]     out_minx_reg, out_maxx_reg, out_miny_reg, out_maxy_reg;
    logic [CNT_W-1:0]       out_cnt_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign clr_last  = (clr_row_reg == LAST_ROW);
    assign last_cell = (cx_reg == tx_reg) && (cy_reg == ty_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        CMD_TRACE: state_next = ST_WALK;
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_NOP:   state_next = ST_RESP;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_WALK:  if (last_cell) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_RESP;
            ST_READ:  state_next = ST_RESP;
            ST_CLEAR: if (clr_last) state_next = ST_RESP;
            ST_RESP:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pop_now  = (state_reg == ST_IDLE) && cmd_valid;
        issue    = (state_reg == ST_WALK);
        clearing = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        load_out = (state_reg == ST_RESP) && out_free;
        ready    = (state_reg != ST_INIT);
    end

    assign cmd_pop = pop_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walker set-up from the command: distances and step directions.
    always_comb
    begin
        ld_ddx = signed'(ERR_W'(cmd.bx)) - signed'(ERR_W'(cmd.ax));
        ld_ddy = signed'(ERR_W'(cmd.by)) - signed'(ERR_W'(cmd.ay));
        ld_dx  = ld_ddx[ERR_W-1] ? -ld_ddx : ld_ddx;
        ld_dy  = ld_ddy[ERR_W-1] ? -ld_ddy : ld_ddy;
    end

    // One line step: the doubled error decides which axes advance.
    always_comb
    begin
        e2       = signed'({err_reg, 1'b0});
        dx_e     = E2_W'(dx_reg);
        dy_n     = -E2_W'(dy_reg);
        step_x   = (e2 > dy_n);
        step_y   = (e2 < dx_e);
        err_step = err_reg - (step_x ? dy_reg : ERR_ZERO) + (step_y ? dx_reg : ERR_ZERO);
        cx_step  = step_x ? (sx_reg ? cx_reg + COORD_W'(1) : cx_reg - COORD_W'(1)) : cx_reg;
        cy_step  = step_y ? (sy_reg ? cy_reg + COORD_W'(1) : cy_reg - COORD_W'(1)) : cy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop_now)
        begin
            cx_reg  <= cmd.ax;
            cy_reg  <= cmd.ay;
            tx_reg  <= cmd.bx;
            ty_reg  <= cmd.by;
            dx_reg  <= ld_dx;
            dy_reg  <= ld_dy;
            err_reg <= ld_dx - ld_dy;
            sx_reg  <= (cmd.ax < cmd.bx);
            sy_reg  <= (cmd.ay < cmd.by);
            hit_reg <= cmd.hit;
        end
        else if (issue)
        begin
            cx_reg  <= cx_step;
            cy_reg  <= cy_step;
            err_reg <= err_step;
        end
    end

    // Read address: the command's cell while idle, else the walker's cell.
    always_comb
    begin
        rd_x    = (state_reg == ST_IDLE) ? cmd.ax : cx_reg;
        rd_y    = (state_reg == ST_IDLE) ? cmd.ay : cy_reg;
        rd_row  = AW'(rd_y);
        rd_addr = SIDE_C * CAW'(rd_row) + CAW'(AW'(rd_x));
    end

    // Increment for the issued cell: the end cell may be a hit.
    assign issue_inc = (last_cell && hit_reg) ? signed'(INC_W'(cfg.hit_increment))
                                              : cfg.miss_increment;

    // Update stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            b_valid_reg <= issue;
            // A cell in the same row as the one being written reads a stale row.
            fwd_reg     <= b_valid_reg && (rd_row == AW'(b_y_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_x_reg    <= cx_reg;
            b_y_reg    <= cy_reg;
            b_addr_reg <= rd_addr;
            b_inc_reg  <= issue_inc;
        end
        fwd_row_reg <= row_new;
    end

    // Read-modify-write of one cell: add, clamp to the limits, then saturate.
    always_comb
    begin
        row_eff = fwd_reg ? fwd_row_reg : row_rd_reg;
        fresh   = !row_eff[AW'(b_x_reg)];
        row_new = row_eff;
        row_new[AW'(b_x_reg)] = 1'b1;
        old_v   = fresh ? '0 : val_rd_reg;
        old_ext = SUM_W'(old_v);
        inc_ext = SUM_W'(b_inc_reg);
        sum     = old_ext + inc_ext;
        max_ext = signed'(SUM_W'(cfg.max_log_odds));
        min_ext = SUM_W'(cfg.min_log_odds);
        v1      = (sum > max_ext) ? max_ext : sum;
        v2      = (v1 < min_ext) ? min_ext : v1;
        if (v2 > LIM_HI)
        begin
            v3 = LIM_HI;
        end
        else if (v2 < LIM_LO)
        begin
            v3 = LIM_LO;
        end
        else
        begin
            v3 = v2;
        end
        new_val = LW'(v3);
    end

    // Row write port is shared by the update stage and the clearing sweep.
    always_comb
    begin
        row_we      = b_valid_reg || clearing;
        row_wr_idx  = clearing ? clr_row_reg : AW'(b_y_reg);
        row_wr_data = clearing ? '0 : row_new;
    end

    // Cell value memory.
    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            value_mem[b_addr_reg] <= new_val;
        end
        val_rd_reg <= value_mem[rd_addr];
    end

    // Observed bit memory.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            seen_mem[row_wr_idx] <= row_wr_data;
        end
        row_rd_reg <= seen_mem[rd_row];
    end

    // Row counter of the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
        end
        else if (clearing)
        begin
            clr_row_reg <= clr_last ? '0 : clr_row_reg + AW'(1);
        end
    end

    // Bounding box and observed count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            bmin_x_reg    <= '0;
            bmax_x_reg    <= '0;
            bmin_y_reg    <= '0;
            bmax_y_reg    <= '0;
            cnt_reg       <= '0;
        end
        else if (pop_now && (cmd.op == CMD_CLEAR))
        begin
            bnd_valid_reg <= 1'b0;
            bmin_x_reg    <= '0;
            bmax_x_reg    <= '0;
            bmin_y_reg    <= '0;
            bmax_y_reg    <= '0;
            cnt_reg       <= '0;
        end
        else if (b_valid_reg && fresh)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (!bnd_valid_reg)
            begin
                bnd_valid_reg <= 1'b1;
                bmin_x_reg    <= b_x_reg;
                bmax_x_reg    <= b_x_reg;
                bmin_y_reg    <= b_y_reg;
                bmax_y_reg    <= b_y_reg;
            end
            else
            begin
                if (b_x_reg < bmin_x_reg) bmin_x_reg <= b_x_reg;
                if (b_x_reg > bmax_x_reg) bmax_x_reg <= b_x_reg;
                if (b_y_reg < bmin_y_reg) bmin_y_reg <= b_y_reg;
                if (b_y_reg > bmax_y_reg) bmax_y_reg <= b_y_reg;
            end
        end
    end

    // Cell fields of the result: zero except for a read of an observed cell.
    always_ff @(posedge clk)
    begin
        if (pop_now)
        begin
            rd_col_reg  <= AW'(cmd.ax);
            res_val_reg <= '0;
            res_obs_reg <= 1'b0;
        end
        else if (state_reg == ST_READ)
        begin
            res_obs_reg <= row_rd_reg[rd_col_reg];
            res_val_reg <= row_rd_reg[rd_col_reg] ? LO_W'(val_rd_reg) : '0;
        end
    end

    // Output register; it frees the sequencer as soon as the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_val_reg  <= res_val_reg;
            out_obs_reg  <= res_obs_reg;
            out_bv_reg   <= bnd_valid_reg;
            out_minx_reg <= bmin_x_reg;
            out_maxx_reg <= bmax_x_reg;
            out_miny_reg <= bmin_y_reg;
            out_maxy_reg <= bmax_y_reg;
            out_cnt_reg  <= cnt_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.cell_log_odds  = out_val_reg;
    assign rsp.cell_observed  = out_obs_reg;
    assign rsp.has_bounds     = out_bv_reg;
    assign rsp.bound_min_x    = out_minx_reg;
    assign rsp.bound_max_x    = out_maxx_reg;
    assign rsp.bound_min_y    = out_miny_reg;
    assign rsp.bound_max_y    = out_maxy_reg;
    assign rsp.observed_count = out_cnt_reg;

endmodule

// ===== hw/rtl/occupancy_grid_ray_update_unit.sv =====
// Top level of the occupancy grid ray update unit: configuration registers and block wiring.
`timescale 1ns / 1ps

// Keeps a GRID_SIDE x GRID_SIDE map of signed Q8.8 log-odds cells with observed
// bits, and serves trace, read and clear requests with exactly one result each.
// Requests pass through a short command queue to a sequencer that owns the cell
// memories. A trace walks the N = max(|dx|, |dy|) + 1 cells on the line (up to
// GRID_SIDE): the cell memories take one read-modify-write per cell, one cell per
// cycle. A clear sweeps the observed bits one row per cycle. After reset the unit
// sweeps the observed bits in the same way and accepts no request until that is
// done; configuration writes are taken at any time and must only be issued while
// no request is outstanding.

module occupancy_grid_ray_update_unit import ogru_pkg::*; #(
    parameter int GRID_SIDE      = GRID_SIDE_DEF,
    parameter int LOG_ODDS_WIDTH = LOG_ODDS_WIDTH_DEF,
    parameter int QUEUE_DEPTH    = CMD_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ogru_req_if.sink              req,
    ogru_rsp_if.source            rsp
);

    cfg_t cfg_reg;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    logic back_ready;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_increment  <= HIT_INC_RST;
            cfg_reg.miss_increment <= MISS_INC_RST;
            cfg_reg.min_log_odds   <= MIN_LO_RST;
            cfg_reg.max_log_odds   <= MAX_LO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIT_INC:  cfg_reg.hit_increment  <= cfg_data[HIT_W-1:0];
                CFG_MISS_INC: cfg_reg.miss_increment <= signed'(cfg_data[INC_W-1:0]);
                CFG_MIN_LO:   cfg_reg.min_log_odds   <= signed'(cfg_data[LO_W-1:0]);
                CFG_MAX_LO:   cfg_reg.max_log_odds   <= cfg_data[MAX_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    ogru_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .req        (req),
        .queue_full (queue_full),
        .back_ready (back_ready),
        .push       (push),
        .cmd        (push_cmd)
    );

    ogru_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_cmd),
        .empty     (queue_empty)
    );

    ogru_back #(
        .GRID_SIDE      (GRID_SIDE),
        .LOG_ODDS_WIDTH (LOG_ODDS_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (!queue_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .ready     (back_ready),
        .rsp       (rsp)
    );

endmodule
